FILE: rtl/sblru_pkg.sv
// Shared constants, types and codes for the size-budget LRU cache directory.
`default_nettype none

package sblru_pkg;

    localparam int ENTRIES    = 16;
    localparam int TAG_BITS   = 64;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    localparam int KEY_W      = 64;
    localparam int SIZE_W     = 17;
    localparam int BYTES_W    = 21;
    localparam int SLOT_W     = 4;
    localparam int EVICT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [BYTES_W-1:0] CAPACITY_RESET   = BYTES_W'(1048576);
    localparam logic [SIZE_W-1:0]  MAX_OBJECT_RESET = SIZE_W'(102400);

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OBJECT = CFG_IDX_W'(1);

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PICK,
        S_TOUCH,
        S_EVICT,
        S_FILL,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic start;
        logic match;
        logic pick;
        logic touch;
        logic set_reject;
        logic evict;
        logic fill;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic reject;
        logic over;
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/sblru_ctrl.sv
// Controller state machine: sequences lookup, eviction and fill steps.
`default_nettype none

module sblru_ctrl
    import sblru_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.kind == KIND_LOOKUP) begin
                    n_state = S_PICK;
                end else if (i_stat.reject) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_EVICT;
                end
            end
            S_PICK:  n_state = S_TOUCH;
            S_TOUCH: n_state = S_RESULT;
            S_EVICT: begin
                if (!(i_stat.over && !i_stat.empty)) begin
                    n_state = S_FILL;
                end
            end
            S_FILL:  n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   o_cmd.start = i_in_valid;
            S_DECODE: begin
                o_cmd.match      = 1'b1;
                o_cmd.set_reject = (i_stat.kind == KIND_INSERT) && i_stat.reject;
            end
            S_PICK:   o_cmd.pick  = 1'b1;
            S_TOUCH:  o_cmd.touch = 1'b1;
            // one victim a cycle while over budget, then one more if still full
            S_EVICT:  o_cmd.evict = (i_stat.over && !i_stat.empty) || i_stat.full;
            S_FILL:   o_cmd.fill  = 1'b1;
            S_RESULT: o_cmd.load_out = out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/sblru_dp.sv
// Datapath: entry store, recency ranks, byte total, config registers, result registers.
`default_nettype none

module sblru_dp
    import sblru_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic                  i_kind,
    input  wire logic [KEY_W-1:0]      i_key_tag,
    input  wire logic [SIZE_W-1:0]     i_object_bytes,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_hit,
    output logic                       o_rejected,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [EVICT_W-1:0]         o_evicted_count,
    output logic [BYTES_W-1:0]         o_used_bytes
);

    // control state
    logic [ENTRIES-1:0]  r_valid;
    logic [IDX_W-1:0]    r_rank [ENTRIES];
    logic [CNT_W-1:0]    r_count;
    logic [BYTES_W-1:0]  r_total;
    logic [BYTES_W-1:0]  r_cap;
    logic [SIZE_W-1:0]   r_max;

    // entry payload
    logic [TAG_BITS-1:0] r_tag_arr  [ENTRIES];
    logic [SIZE_W-1:0]   r_size_arr [ENTRIES];

    // current item and working registers
    logic                r_kind;
    logic [TAG_BITS-1:0] r_key;
    logic [SIZE_W-1:0]   r_size;
    logic [ENTRIES-1:0]  r_match;
    logic                r_found;
    logic [IDX_W-1:0]    r_kbest;

    logic                r_res_hit;
    logic                r_res_rej;
    logic [IDX_W-1:0]    r_res_slot;
    logic [CNT_W-1:0]    r_res_evicted;

    logic                r_out_hit;
    logic                r_out_rej;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [EVICT_W-1:0]  r_out_evicted;
    logic [BYTES_W-1:0]  r_out_used;

    logic [CNT_W-1:0]    cnt_m1;
    logic [IDX_W-1:0]    vic_idx;
    logic [ENTRIES-1:0]  rank_hit;
    logic [IDX_W-1:0]    kbest;
    logic [IDX_W-1:0]    sel_idx;
    logic [IDX_W-1:0]    free_idx;
    logic [BYTES_W:0]    need_bytes;
    logic [BYTES_W:0]    fill_sum;

    assign cnt_m1     = r_count - CNT_W'(1);
    assign need_bytes = {1'b0, r_total} + (BYTES_W + 1)'(r_size);
    assign fill_sum   = need_bytes;

    // least recent valid entry: its rank is one below the fill count
    always_comb begin
        vic_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && (r_rank[i] == cnt_m1[IDX_W-1:0])) begin
                vic_idx = vic_idx | IDX_W'(i);
            end
        end
    end

    // most recent matching rank
    always_comb begin
        rank_hit = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_match[i] && (r_rank[i] == IDX_W'(k))) begin
                    rank_hit[k] = 1'b1;
                end
            end
        end
        kbest = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (rank_hit[k]) begin
                kbest = IDX_W'(k);
            end
        end
    end

    always_comb begin
        sel_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_match[i] && (r_rank[i] == r_kbest)) begin
                sel_idx = sel_idx | IDX_W'(i);
            end
        end
    end

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_stat.kind   = r_kind;
        o_stat.reject = (r_size == '0) || (r_size > r_max);
        o_stat.over   = need_bytes > (BYTES_W + 1)'(r_cap);
        o_stat.empty  = (r_count == '0);
        o_stat.full   = (r_count == CNT_W'(ENTRIES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_total <= '0;
            r_cap   <= CAPACITY_RESET;
            r_max   <= MAX_OBJECT_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CAPACITY:   r_cap <= i_cfg_data[BYTES_W-1:0];
                    CFG_MAX_OBJECT: r_max <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.touch && r_found) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (r_rank[i] == r_kbest)) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < r_kbest)) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
            end
            if (i_cmd.evict) begin
                r_valid[vic_idx] <= 1'b0;
                r_rank[vic_idx]  <= '0;
                r_count          <= cnt_m1;
                r_total          <= r_total - BYTES_W'(r_size_arr[vic_idx]);
            end
            if (i_cmd.fill) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                r_valid[free_idx] <= 1'b1;
                r_rank[free_idx]  <= '0;
                r_count           <= r_count + CNT_W'(1);
                r_total           <= fill_sum[BYTES_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind        <= i_kind;
            r_key         <= i_key_tag[TAG_BITS-1:0];
            r_size        <= i_object_bytes;
            r_res_hit     <= 1'b0;
            r_res_rej     <= 1'b0;
            r_res_slot    <= '0;
            r_res_evicted <= '0;
        end
        if (i_cmd.match) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_match[i] <= r_valid[i] && (r_tag_arr[i] == r_key);
            end
        end
        if (i_cmd.set_reject) begin
            r_res_rej <= 1'b1;
        end
        if (i_cmd.pick) begin
            r_found <= |r_match;
            r_kbest <= kbest;
        end
        if (i_cmd.touch && r_found) begin
            r_res_hit  <= 1'b1;
            r_res_slot <= sel_idx;
        end
        if (i_cmd.evict) begin
            r_res_evicted <= r_res_evicted + CNT_W'(1);
        end
        if (i_cmd.fill) begin
            r_tag_arr[free_idx]  <= r_key;
            r_size_arr[free_idx] <= r_size;
            r_res_slot           <= free_idx;
        end
        if (i_cmd.load_out) begin
            r_out_hit     <= r_res_hit;
            r_out_rej     <= r_res_rej;
            r_out_slot    <= SLOT_W'(r_res_slot);
            r_out_evicted <= EVICT_W'(r_res_evicted);
            r_out_used    <= r_total;
        end
    end

    assign o_hit           = r_out_hit;
    assign o_rejected      = r_out_rej;
    assign o_slot          = r_out_slot;
    assign o_evicted_count = r_out_evicted;
    assign o_used_bytes    = r_out_used;

endmodule

`default_nettype wire

FILE: rtl/size_budget_lru_cache.sv
// Top level of the size-budget LRU cache directory.
// Tracks up to ENTRIES objects (tag and byte size) in recency order. One item is worked on at
// a time and the next is taken once its result sits in the output register, even if that
// result has not yet been taken. A lookup steps through decode, pick, touch and result; a
// rejected insert through decode and result; an accepted insert through decode, evict, fill
// and result, with e entries evicted to fit the byte budget (at most ENTRIES), as the
// eviction loop removes one least recent entry per cycle. The extra eviction for a full
// directory shares the final pass of that loop. A result stalled at the output holds the
// block once the next item reaches its result step. Configuration writes are always ready.
`default_nettype none

module size_budget_lru_cache
    import sblru_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_kind,
    input  wire logic [KEY_W-1:0]      i_key_tag,
    input  wire logic [SIZE_W-1:0]     i_object_bytes,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_hit,
    output logic                       o_rejected,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [EVICT_W-1:0]         o_evicted_count,
    output logic [BYTES_W-1:0]         o_used_bytes,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    sblru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sblru_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_kind),
        .i_key_tag       (i_key_tag),
        .i_object_bytes  (i_object_bytes),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_hit           (o_hit),
        .o_rejected      (o_rejected),
        .o_slot          (o_slot),
        .o_evicted_count (o_evicted_count),
        .o_used_bytes    (o_used_bytes)
    );

endmodule

`default_nettype wire

FILE: rtl/sblru_chk.sv
// Port-level checker for the size-budget LRU cache directory, with its bind.
`default_nettype none

module sblru_chk
    import sblru_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_hit,
    input wire logic               o_rejected,
    input wire logic [SLOT_W-1:0]  o_slot,
    input wire logic [EVICT_W-1:0] o_evicted_count,
    input wire logic [BYTES_W-1:0] o_used_bytes
);

    // one item at a time: a transfer in closes the input until the work is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again straight after a transfer");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |->
            (!o_hit && (o_slot == '0) && (o_evicted_count == '0)))
        else $error("rejected insert reports hit, slot or evictions");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (!o_rejected && (o_evicted_count == '0)))
        else $error("lookup hit reports rejection or evictions");

    a_evict_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_evicted_count) <= 32'(ENTRIES)))
        else $error("more evictions than entries");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_used_bytes)))
        else $error("stalled result changed");

endmodule

bind size_budget_lru_cache sblru_chk u_sblru_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_hit           (o_hit),
    .o_rejected      (o_rejected),
    .o_slot          (o_slot),
    .o_evicted_count (o_evicted_count),
    .o_used_bytes    (o_used_bytes)
);

`default_nettype wire
